>>> design/tsw_pkg.sv
// shared types and constants for the tcp sender window engine
`default_nettype none
package tsw_pkg;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_EMPTY = 2'd3
  } op_e;

  localparam logic CFG_IDX_SEQ     = 1'b0;
  localparam logic CFG_IDX_TIMEOUT = 1'b1;
  localparam int   CFG_W           = 32;
  localparam int   CFG_IDX_W       = 1;

  // ring entry: seqno, payload length, syn, fin
  typedef struct packed {
    logic [31:0] seqno;
    logic [15:0] plen;
    logic        syn;
    logic        fin;
  } seg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] buffered_bytes;
    logic        stream_ended;
    logic [31:0] ack_number;
    logic [15:0] window;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic        seg_valid;
    logic [31:0] seqno;
    logic [9:0]  payload_len;
    logic        syn;
    logic        fin;
    logic        retransmit;
    logic        last;
    logic [16:0] in_flight;
    logic [7:0]  retx_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_CALC,
    ST_FILL,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_TICK_RD,
    ST_TICK_OUT,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

>>> design/tsw_if.sv
// valid/ready channel interfaces for items and results
`default_nettype none
interface tsw_in_if;
  import tsw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsw_out_if;
  import tsw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/tsw_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module tsw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/tcp_sender_window_retransmit.sv
// top level of the tcp sender sequence and retransmission engine
`default_nettype none
// Takes one command transaction at a time and returns one or more segment
// descriptor transactions; the final one of a command carries last. A fill
// first dry-runs the fill loop over its segments and the stop check to learn
// the final in-flight count, then emits one segment per cycle while the
// output is not stalled; a fill that sends nothing goes on to the closing
// transaction. Each pop of an ack needs a registered read of the outstanding
// ring memory; an ignored ack pops nothing. A tick retransmits at most one
// segment; an empty segment returns one result. A new command is taken only
// in idle. The ring holds no valid bits: only written entries are ever read.
// No clearing pass.
module tcp_sender_window_retransmit
  import tsw_pkg::*;
#(
  parameter int MAX_PAYLOAD       = 1000,
  parameter int OUTSTANDING_DEPTH = 64,
  parameter int MAX_SEGS_PER_FILL = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tsw_in_if.sink                    in_if,
  tsw_out_if.source                 out_if,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);
  localparam int AW = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
  localparam int CW = $clog2(OUTSTANDING_DEPTH + 1);
  localparam int NW = $clog2(MAX_SEGS_PER_FILL + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(OUTSTANDING_DEPTH);
  localparam logic [NW-1:0] MAXN_C  = NW'(MAX_SEGS_PER_FILL);
  localparam logic [16:0]   MAXP_C  = 17'(MAX_PAYLOAD);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(OUTSTANDING_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(OUTSTANDING_DEPTH - 1);

  state_e state_q, state_d;
  in_item_t cmd_q, cmd_d;
  logic [31:0] iseq_q, iseq_d;
  logic [15:0] itmo_q, itmo_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [63:0] sent_q, sent_d, acked_q, acked_d, now_q, now_d, dl_q, dl_d;
  logic [31:0] tmo_q, tmo_d;
  logic timer_q, timer_d, syn_q, syn_d, fin_q, fin_d;
  logic [7:0] retx_q, retx_d;
  logic [15:0] pwin_q, pwin_d;
  logic [15:0] buf_q, buf_d;
  logic [NW-1:0] n_q, n_d;
  logic ovalid_q, ovalid_d;
  out_item_t odata_q, odata_d;
  logic [63:0] snap_sent_q, snap_sent_d;
  logic snap_syn_q, snap_syn_d, snap_fin_q, snap_fin_d;
  logic [NW-1:0] tot_q, tot_d;
  logic [16:0] fl_fin_q, fl_fin_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  seg_t ram_wdata, ram_rdata;

  tsw_ram #(.Width($bits(seg_t)), .Depth(OUTSTANDING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // helper values
  logic [63:0] fl64;
  logic [16:0] fl_sat;
  logic [16:0] rwnd, room, take;
  logic        fill_go;
  seg_t        s_new;
  logic [16:0] s_len;
  logic [31:0] next_seq, ack_d32, ack_dist;
  logic [16:0] head_len;
  logic        out_free;
  logic        fill_last;
  logic [AW:0] tail_sum;
  logic [AW-1:0] tail_addr, head_inc;

  always_comb begin
    fl64     = sent_q - acked_q;
    fl_sat   = (fl64 > 64'h1FFFF) ? 17'h1FFFF : fl64[16:0];
    rwnd     = (pwin_q == 16'd0) ? 17'd1 : {1'b0, pwin_q};
    room     = rwnd - fl64[16:0];
    take     = (room < MAXP_C) ? room : MAXP_C;
    if (take > {1'b0, buf_q}) take = {1'b0, buf_q};
    s_new.syn   = ~syn_q;
    s_new.plen  = take[15:0];
    s_new.fin   = cmd_q.stream_ended && ({1'b0, buf_q} == take) && !fin_q &&
                  ({16'd0, ~syn_q} + take + 17'd1 <= room);
    next_seq    = iseq_q + sent_q[31:0];
    s_new.seqno = next_seq;
    s_len    = {1'b0, s_new.plen} + {16'd0, s_new.syn} + {16'd0, s_new.fin};
    fill_go  = (n_q < MAXN_C) && (count_q < DEPTH_C) && (fl64 < {47'd0, rwnd}) &&
               (s_len != 17'd0);
    fill_last = (n_q + NW'(1) == tot_q);
    ack_d32  = cmd_q.ack_number - next_seq;
    ack_dist = cmd_q.ack_number - ram_rdata.seqno;
    head_len = {1'b0, ram_rdata.plen} + {16'd0, ram_rdata.syn} + {16'd0, ram_rdata.fin};
    out_free = !ovalid_q || out_if.ready;
    // ring addresses wrap at the configured depth
    tail_sum  = {1'b0, head_q} + (AW+1)'(count_q);
    tail_addr = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
    head_inc  = (head_q == LAST_C) ? '0 : head_q + AW'(1);
  end

  // next state, datapath and ring access
  always_comb begin
    state_d = state_q; cmd_d = cmd_q; iseq_d = iseq_q; itmo_d = itmo_q;
    head_d = head_q; count_d = count_q; sent_d = sent_q; acked_d = acked_q;
    now_d = now_q; dl_d = dl_q; tmo_d = tmo_q; timer_d = timer_q;
    syn_d = syn_q; fin_d = fin_q; retx_d = retx_q; pwin_d = pwin_q;
    buf_d = buf_q; n_d = n_q;
    snap_sent_d = snap_sent_q; snap_syn_d = snap_syn_q; snap_fin_d = snap_fin_q;
    tot_d = tot_q; fl_fin_d = fl_fin_q;
    ovalid_d = ovalid_q && !out_if.ready; odata_d = odata_q;
    ram_we = 1'b0; ram_waddr = tail_addr; ram_wdata = s_new;
    ram_raddr = head_q;
    in_if.ready = (state_q == ST_IDLE);

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_SEQ: iseq_d = cfg_wdata_i;
        CFG_IDX_TIMEOUT: begin
          itmo_d = cfg_wdata_i[15:0];
          if (!syn_q) tmo_d = {16'd0, cfg_wdata_i[15:0]};
        end
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          cmd_d = in_if.data;
          buf_d = in_if.data.buffered_bytes;
          n_d   = '0;
          snap_sent_d = sent_q;
          snap_syn_d  = syn_q;
          snap_fin_d  = fin_q;
          unique case (op_e'(in_if.data.opcode))
            OP_FILL: begin
              if ((in_if.data.buffered_bytes == 16'd0 && syn_q && !in_if.data.stream_ended)
                  || (in_if.data.stream_ended && fin_q)) begin
                state_d = ST_EMIT;
              end else begin
                state_d = ST_FILL_CALC;
              end
            end
            OP_ACK:  state_d = ST_ACK_RD;
            OP_TICK: begin
              now_d   = now_q + {48'd0, in_if.data.elapsed_ms};
              state_d = ST_TICK_RD;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_FILL_CALC: begin
        // dry run of the fill loop for segment count and final in-flight
        if (fill_go) begin
          count_d = count_q + CW'(1);
          syn_d   = syn_q | s_new.syn;
          fin_d   = fin_q | s_new.fin;
          buf_d   = buf_q - s_new.plen;
          sent_d  = sent_q + {47'd0, s_len};
          n_d     = n_q + NW'(1);
        end else begin
          tot_d    = n_q;
          fl_fin_d = fl_sat;
          sent_d   = snap_sent_q;
          syn_d    = snap_syn_q;
          fin_d    = snap_fin_q;
          count_d  = count_q - CW'(n_q);
          buf_d    = cmd_q.buffered_bytes;
          n_d      = '0;
          state_d  = (n_q == '0) ? ST_EMIT : ST_FILL;
        end
      end
      ST_FILL: begin
        // emit one segment per cycle while the output is free, the final one carries last
        if (out_free) begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
          syn_d   = syn_q | s_new.syn;
          fin_d   = fin_q | s_new.fin;
          buf_d   = buf_q - s_new.plen;
          sent_d  = sent_q + {47'd0, s_len};
          n_d     = n_q + NW'(1);
          if (!timer_q) begin
            timer_d = 1'b1;
            dl_d    = now_q + {32'd0, tmo_q};
          end
          ovalid_d = 1'b1;
          odata_d  = '{seg_valid: 1'b1, seqno: s_new.seqno,
                       payload_len: s_new.plen[9:0], syn: s_new.syn, fin: s_new.fin,
                       retransmit: 1'b0, last: fill_last, in_flight: fl_fin_q,
                       retx_count: retx_q};
          if (fill_last) state_d = ST_IDLE;
        end
      end
      ST_ACK_RD: begin
        // wait for head read; first visit also checks the bound
        if (n_q == '0 && ack_d32 != 32'd0 && !ack_d32[31]) begin
          state_d = ST_EMIT;
        end else begin
          if (n_q == '0) begin
            pwin_d = cmd_q.window;
            tmo_d  = {16'd0, itmo_q};
            retx_d = 8'd0;
            n_d    = NW'(1);
          end
          state_d = ST_ACK_CHK;
        end
      end
      ST_ACK_CHK: begin
        if (count_q != '0 && !ack_dist[31] && ack_dist >= {15'd0, head_len}) begin
          acked_d  = acked_q + {47'd0, head_len};
          head_d   = head_inc;
          ram_raddr = head_inc;
          count_d  = count_q - CW'(1);
          timer_d  = 1'b0;
          state_d  = ST_ACK_RD;
        end else begin
          if (count_q == '0) begin
            timer_d = 1'b0;
          end else if (!timer_q) begin
            timer_d = 1'b1;
            dl_d    = now_q + {32'd0, tmo_q};
          end
          state_d = ST_EMIT;
        end
      end
      ST_TICK_RD: begin
        if (!timer_q || now_q < dl_q) begin
          state_d = ST_EMIT;
        end else if (count_q == '0) begin
          timer_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_TICK_OUT;
        end
      end
      ST_TICK_OUT: begin
        if (!ovalid_q || out_if.ready) begin
          if (pwin_q != 16'd0) begin
            tmo_d = tmo_q[31] ? 32'hFFFF_FFFF : {tmo_q[30:0], 1'b0};
            if (retx_q != 8'hFF) retx_d = retx_q + 8'd1;
          end
          // timer restarts with the new timeout, grown only when the peer window is nonzero
          timer_d = 1'b1;
          dl_d    = now_q + {32'd0, tmo_d};
          n_d     = NW'(1);
          // held until the closing transaction so last and counts are final
          odata_d  = '{seg_valid: 1'b1, seqno: ram_rdata.seqno,
                       payload_len: ram_rdata.plen[9:0], syn: ram_rdata.syn,
                       fin: ram_rdata.fin, retransmit: 1'b1, last: 1'b0,
                       in_flight: '0, retx_count: '0};
          ovalid_d = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // closing transaction with last set
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
          if (op_e'(cmd_q.opcode) == OP_EMPTY) begin
            odata_d = '{seg_valid: 1'b1, seqno: next_seq, payload_len: '0, syn: 1'b0,
                        fin: 1'b0, retransmit: 1'b0, last: 1'b1,
                        in_flight: fl_sat, retx_count: retx_q};
          end else if (op_e'(cmd_q.opcode) == OP_TICK && n_q != '0) begin
            odata_d = odata_q;
            odata_d.last = 1'b1;
            odata_d.in_flight = fl_sat;
            odata_d.retx_count = retx_q;
          end else begin
            odata_d = '{seg_valid: 1'b0, seqno: '0, payload_len: '0, syn: 1'b0,
                        fin: 1'b0, retransmit: 1'b0, last: 1'b1,
                        in_flight: fl_sat, retx_count: retx_q};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; iseq_q <= '0; itmo_q <= 16'd1000;
      head_q <= '0; count_q <= '0; sent_q <= '0; acked_q <= '0; now_q <= '0;
      dl_q <= '0; tmo_q <= 32'd1000; timer_q <= 1'b0; syn_q <= 1'b0;
      fin_q <= 1'b0; retx_q <= '0; pwin_q <= 16'd1; n_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; iseq_q <= iseq_d; itmo_q <= itmo_d;
      head_q <= head_d; count_q <= count_d; sent_q <= sent_d; acked_q <= acked_d;
      now_q <= now_d; dl_q <= dl_d; tmo_q <= tmo_d; timer_q <= timer_d;
      syn_q <= syn_d; fin_q <= fin_d; retx_q <= retx_d; pwin_q <= pwin_d;
      n_q <= n_d; ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    buf_q       <= buf_d;
    odata_q     <= odata_d;
    snap_sent_q <= snap_sent_d;
    snap_syn_q  <= snap_syn_d;
    snap_fin_q  <= snap_fin_d;
    tot_q       <= tot_d;
    fl_fin_q    <= fl_fin_d;
  end
endmodule
`default_nettype wire

>>> design/tsw_checker.sv
// port-level checks for the tcp sender engine, bound to the top level
`default_nettype none
module tsw_checker
  import tsw_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // a flagless result is always the closing one
  a_noseg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.seg_valid |-> out_data.last)
    else $error("empty result without last");

  // a retransmission is the only result of its command
  a_retx_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.retransmit |-> out_data.last && out_data.seg_valid)
    else $error("retransmission not single result");

  // no new command taken the cycle after one is accepted
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");
endmodule

bind tcp_sender_window_retransmit tsw_checker u_tsw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
`default_nettype wire

>>> tb/tb_tcp_sender_window_retransmit.sv
// self-checking testbench for the tcp sender window and retransmission engine
`default_nettype none
module tb_tcp_sender_window_retransmit;
  import tsw_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int SEGS_PER_FILL = 64;
  localparam int MSS = 1000;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;

  // segment tracker: mirrors sequence space, ring and timer, holds expected segments
  class seg_scoreboard;
    logic [31:0] ring_seq [RING_DEPTH];
    logic [15:0] ring_plen [RING_DEPTH];
    bit          ring_syn [RING_DEPTH];
    bit          ring_fin [RING_DEPTH];
    int unsigned head, count;
    longint unsigned sent, acked, now_ms, deadline;
    logic [31:0] cur_timeout, isn;
    logic [15:0] init_timeout, peer_wnd;
    logic [7:0]  retx;
    bit          timer_on, syn_out, fin_out;
    out_item_t   seg_q [$];
    int          errors, n_items, n_results, n_retx, n_fin;

    function new();
      head = 0; count = 0; sent = 0; acked = 0; now_ms = 0; deadline = 0;
      isn = 0; init_timeout = 16'd1000; cur_timeout = 32'd1000; peer_wnd = 16'd1;
      retx = 0; timer_on = 0; syn_out = 0; fin_out = 0;
      errors = 0; n_items = 0; n_results = 0; n_retx = 0; n_fin = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_IDX_SEQ) begin
        isn = val;
      end else if (idx == CFG_IDX_TIMEOUT) begin
        init_timeout = val[15:0];
        if (!syn_out) cur_timeout = {16'd0, val[15:0]};
      end
    endfunction

    function logic [31:0] next_seq();
      return isn + sent[31:0];
    endfunction

    function void arm_timer();
      deadline = now_ms + cur_timeout;
      timer_on = 1;
    endfunction

    function out_item_t make_seg(int unsigned slot, bit is_retx);
      out_item_t r;
      r = '0;
      r.seg_valid = 1;
      r.seqno = ring_seq[slot];
      r.payload_len = ring_plen[slot][9:0];
      r.syn = ring_syn[slot];
      r.fin = ring_fin[slot];
      r.retransmit = is_retx;
      return r;
    endfunction

    // work out the segments one command transaction produces
    function void note_item(in_item_t it);
      out_item_t segs [$];
      out_item_t r;
      longint unsigned fl;
      int unsigned rwnd, room, take, buf_left, slen, slot;
      logic [31:0] d, ack_gap;
      bit s_syn, s_fin;
      n_items++;
      case (op_e'(it.opcode))
        OP_FILL: begin
          rwnd = (peer_wnd != 0) ? peer_wnd : 1;
          buf_left = it.buffered_bytes;
          if (!((buf_left == 0 && syn_out && !it.stream_ended) ||
                (it.stream_ended && fin_out))) begin
            while (segs.size() < SEGS_PER_FILL && count < RING_DEPTH) begin
              fl = sent - acked;
              if (fl >= rwnd) break;
              room = rwnd - 32'(fl);
              take = (room < MSS) ? room : MSS;
              if (take > buf_left) take = buf_left;
              s_syn = !syn_out;
              s_fin = it.stream_ended && buf_left == take && !fin_out &&
                      (s_syn + take + 1 <= room);
              slen = take + s_syn + s_fin;
              if (slen == 0) break;
              buf_left -= take;
              if (s_syn) syn_out = 1;
              if (s_fin) begin
                fin_out = 1;
                n_fin++;
              end
              slot = (head + count) % RING_DEPTH;
              ring_seq[slot] = next_seq();
              ring_plen[slot] = take[15:0];
              ring_syn[slot] = s_syn;
              ring_fin[slot] = s_fin;
              sent += slen;
              count++;
              segs.push_back(make_seg(slot, 0));
              if (!timer_on) arm_timer();
            end
          end
        end
        OP_ACK: begin
          d = it.ack_number - next_seq();
          if (d == 0 || d[31]) begin
            peer_wnd = it.window;
            cur_timeout = {16'd0, init_timeout};
            retx = 0;
            while (count > 0) begin
              ack_gap = it.ack_number - ring_seq[head];
              slen = ring_plen[head] + ring_syn[head] + ring_fin[head];
              if (ack_gap[31] || ack_gap < slen) break;
              acked += slen;
              head = (head + 1) % RING_DEPTH;
              count--;
              timer_on = 0;
            end
            if (count == 0) timer_on = 0;
            else if (!timer_on) arm_timer();
          end
        end
        OP_TICK: begin
          now_ms += it.elapsed_ms;
          if (timer_on && now_ms >= deadline) begin
            if (count == 0) begin
              timer_on = 0;
            end else begin
              segs.push_back(make_seg(head, 1));
              n_retx++;
              if (peer_wnd != 0) begin
                cur_timeout = cur_timeout[31] ? 32'hFFFF_FFFF : cur_timeout << 1;
                if (retx != 8'hFF) retx++;
              end
              arm_timer();
            end
          end
        end
        default: begin
          r = '0;
          r.seg_valid = 1;
          r.seqno = next_seq();
          segs.push_back(r);
        end
      endcase
      // a command with no segment still answers with one empty result
      if (segs.size() == 0) segs.push_back('0);
      fl = sent - acked;
      if (fl > 64'h1FFFF) fl = 64'h1FFFF;
      foreach (segs[k]) begin
        segs[k].last = (k == segs.size() - 1);
        segs[k].in_flight = fl[16:0];
        segs[k].retx_count = retx;
        seg_q.push_back(segs[k]);
      end
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g)
        $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, g);
    endfunction

    // compare one result transaction with the oldest expected one
    function void check_result(out_item_t got);
      out_item_t e;
      n_results++;
      if (seg_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
        return;
      end
      e = seg_q.pop_front();
      if (got !== e) begin
        errors++;
        cmp("seg_valid", e.seg_valid, got.seg_valid);
        cmp("seqno", e.seqno, got.seqno);
        cmp("payload_len", e.payload_len, got.payload_len);
        cmp("syn", e.syn, got.syn);
        cmp("fin", e.fin, got.fin);
        cmp("retransmit", e.retransmit, got.retransmit);
        cmp("last", e.last, got.last);
        cmp("in_flight", e.in_flight, got.in_flight);
        cmp("retx_count", e.retx_count, got.retx_count);
      end
    endfunction

    // pick an ack number: mostly plausible, sometimes stale or impossible
    function logic [31:0] pick_ack();
      int unsigned sel, slot;
      sel = $urandom_range(0, 9);
      if (sel <= 3) return next_seq();
      if (sel <= 6 && count > 0) begin
        slot = (head + $urandom_range(0, count - 1)) % RING_DEPTH;
        return ring_seq[slot] + ring_plen[slot] + ring_syn[slot] + ring_fin[slot];
      end
      if (sel == 7) return next_seq() - $urandom_range(0, 3000);
      if (sel == 8) return next_seq() + $urandom_range(1, 70000);
      return $urandom;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int unsigned cycles = 0;
  int stall_mode = 0;
  bit hold_req = 0;
  bit no_gaps = 0;
  seg_scoreboard sb = new();

  tsw_in_if  in_if ();
  tsw_out_if out_if ();

  tcp_sender_window_retransmit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result receiver with its own stall pattern and one long hold-off
  initial begin
    int unsigned k;
    k = 0;
    out_if.ready <= 0;
    forever begin
      @(posedge clk_i);
      k++;
      if (hold_req) begin
        out_if.ready <= 0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 0;
      end else begin
        case (stall_mode)
          0: out_if.ready <= 1;
          1: out_if.ready <= ($urandom_range(0, 9) < 6);
          default: out_if.ready <= ((k % 7) < 3);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // offer one command transaction and keep valid up until it is taken
  task automatic send_item(in_item_t it);
    in_if.valid <= 1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n != 0) begin
      in_if.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_op(op_e op, int unsigned bufb, bit ended, logic [31:0] ackno,
                         int unsigned wnd, int unsigned el);
    in_item_t it;
    it.opcode = op;
    it.buffered_bytes = bufb[15:0];
    it.stream_ended = ended;
    it.ack_number = ackno;
    it.window = wnd[15:0];
    it.elapsed_ms = el[15:0];
    send_item(it);
  endtask

  // wait until every expected segment has come back, then let the engine settle
  task automatic drain();
    idle_gap(1);
    while (sb.seg_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic rand_item(bit allow_end);
    in_item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    it.opcode = (sel < 35) ? OP_FILL : (sel < 70) ? OP_ACK : (sel < 90) ? OP_TICK : OP_EMPTY;
    it.buffered_bytes = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3000));
    it.stream_ended = (it.opcode == OP_FILL) ? (allow_end && $urandom_range(0, 3) == 0)
                                             : 1'($urandom_range(0, 1));
    it.ack_number = (it.opcode == OP_ACK) ? sb.pick_ack() : $urandom;
    it.window = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
    it.elapsed_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 600));
    send_item(it);
  endtask

  initial begin
    int unsigned burst;
    rst_ni <= 0;
    cfg_we_i <= 0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_if.valid <= 0;
    in_if.data <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: sequence wrap, zero window, timeouts, full ring, stale acks
    write_reg(CFG_IDX_SEQ, 32'hFFFF_FFF8);
    write_reg(CFG_IDX_TIMEOUT, 32'd50);
    send_op(OP_FILL, 0, 0, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0, 0, 0);
    send_op(OP_TICK, 0, 1, 0, 0, 60);
    send_op(OP_ACK, 0, 0, sb.next_seq() + 5, 100, 0);
    send_op(OP_ACK, 0, 0, sb.next_seq(), 0, 0);
    send_op(OP_FILL, 500, 0, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0, 0, 65535);
    send_op(OP_ACK, 0, 0, sb.next_seq(), 65535, 0);
    send_op(OP_FILL, 65535, 0, 32'hFFFF_FFFF, 0, 0);
    send_op(OP_FILL, 65535, 0, 0, 0, 0);
    send_op(OP_ACK, 0, 0, sb.ring_seq[sb.head] + 300, 65535, 0);
    send_op(OP_EMPTY, 65535, 1, 32'hFFFF_FFFF, 65535, 65535);
    send_op(OP_TICK, 0, 0, 0, 0, 65535);
    send_op(OP_TICK, 0, 0, 0, 0, 65535);
    send_op(OP_ACK, 0, 0, sb.next_seq() - 32'd100000, 3000, 0);
    send_op(OP_ACK, 0, 0, sb.next_seq(), 1000, 0);
    send_op(OP_FILL, 2000, 1, 0, 0, 0);
    send_op(OP_ACK, 0, 0, sb.next_seq(), 0, 0);
    send_op(OP_FILL, 0, 0, 0, 0, 0);
    drain();

    // random phases with different register settings and stall patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_IDX_TIMEOUT, 32'd0);
          write_reg(CFG_IDX_SEQ, 32'd0);
        end
        1: write_reg(CFG_IDX_TIMEOUT, 32'd65535);
        2: write_reg(CFG_IDX_SEQ, 32'hFFFF_FFFF);
        default: begin
          write_reg(CFG_IDX_SEQ, $urandom);
          write_reg(CFG_IDX_TIMEOUT, $urandom_range(1, 2000));
        end
      endcase
      stall_mode = ph % 3;
      no_gaps = (ph == 1);
      // back pressure: receiver holds off while large fills stack up
      if (ph == 2) begin
        send_op(OP_ACK, 0, 0, sb.next_seq(), 65535, 0);
        hold_req = 1;
        send_op(OP_FILL, 65535, 0, 0, 0, 0);
        send_op(OP_ACK, 0, 0, sb.pick_ack(), 65535, 0);
        send_op(OP_FILL, 65535, 0, 0, 0, 0);
        drain();
      end
      burst = $urandom_range(1, 8);
      for (int i = 0; i < 16; i++) begin
        rand_item(ph == 5);
        if (--burst == 0) begin
          burst = $urandom_range(1, 8);
          if (!no_gaps) idle_gap($urandom_range(1, 6));
        end
      end
      drain();
    end

    $display("items %0d, results %0d, retransmissions %0d, fin segments %0d",
             sb.n_items, sb.n_results, sb.n_retx, sb.n_fin);
    if (sb.seg_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.seg_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
